// ----- rtl/fdps_pkg.sv -----
// ----------------------------------------------------------------------------
// fdps_pkg
// Shared widths, codes, defaults and the result record of the flap drum
// position sequencer.
// ----------------------------------------------------------------------------
package fdps_pkg;

  // Defaults for the top-level parameters.
  localparam int STEPS_PER_REV_DEF = 2038;
  localparam int FLAP_COUNT_DEF    = 45;
  localparam int ESCAPE_STEPS_DEF  = 50;

  // Field widths.
  localparam int CMD_W      = 2;
  localparam int FLAP_W     = 6;
  localparam int OFFSET_W   = 8;
  localparam int COOLDOWN_W = 16;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_HOME_OFFSET = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COOLDOWN    = 1'd1;

  localparam logic [OFFSET_W-1:0]   HOME_OFFSET_RST = 8'd74;
  localparam logic [COOLDOWN_W-1:0] COOLDOWN_RST    = 16'd2000;

  // Command codes of an input word.
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TARGET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_HOME   = 2'd2;

  // One result word.
  typedef struct packed {
    logic              step_pulse;
    logic              motor_enabled;
    logic              busy_rotating;
    logic [FLAP_W-1:0] shown_flap;
    logic              home_failed;
  } result_t;

endpackage

// ----- rtl/fdps_core.sv -----
// ----------------------------------------------------------------------------
// fdps_core
// Sequencer state and the per-word update: homing phases, forward stepping
// with the fractional step numerator, and the move cooldown.
// ----------------------------------------------------------------------------
module fdps_core #(
  parameter int STEPS_PER_REV = fdps_pkg::STEPS_PER_REV_DEF,
  parameter int FLAP_COUNT    = fdps_pkg::FLAP_COUNT_DEF,
  parameter int ESCAPE_STEPS  = fdps_pkg::ESCAPE_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            go,
  input  logic [fdps_pkg::CMD_W-1:0]      cmd,
  input  logic [fdps_pkg::FLAP_W-1:0]     target,
  input  logic                            hall,
  input  logic [fdps_pkg::OFFSET_W-1:0]   home_offset,
  input  logic [fdps_pkg::COOLDOWN_W-1:0] cooldown_ticks,
  output fdps_pkg::result_t               result
);

  localparam int FLAP_STEPS = STEPS_PER_REV / FLAP_COUNT;
  localparam int FLAP_REM   = STEPS_PER_REV % FLAP_COUNT;
  localparam int SEEK_LIMIT = 3 * STEPS_PER_REV;
  localparam int STEP_MAX   = (FLAP_STEPS + 1 > 255) ? FLAP_STEPS + 1 : 255;
  localparam int STEP_W     = $clog2(STEP_MAX + 1);
  localparam int SEEK_W     = $clog2(SEEK_LIMIT + 2);
  localparam int FRAC_W     = fdps_pkg::FLAP_W;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HOME,
    PH_ESCAPE,
    PH_SEEK,
    PH_OFFSET,
    PH_FWD
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [fdps_pkg::FLAP_W-1:0]     shown_r, shown_nxt;
  logic [fdps_pkg::FLAP_W-1:0]     wanted_r, wanted_nxt;
  logic [FRAC_W-1:0]               frac_r, frac_nxt;
  logic [fdps_pkg::FLAP_W-1:0]     flaps_r, flaps_nxt;
  logic [STEP_W-1:0]               steps_r, steps_nxt;
  logic [SEEK_W-1:0]               seek_r, seek_nxt;
  logic [fdps_pkg::COOLDOWN_W-1:0] cool_r, cool_nxt;
  logic                            pend_r, pend_nxt;
  logic                            fail_r, fail_nxt;
  logic                            pulse;
  logic                            halt;
  logic [FRAC_W:0]                 frac_sum;

  always_comb begin
    phase_nxt  = phase_r;
    shown_nxt  = shown_r;
    wanted_nxt = wanted_r;
    frac_nxt   = frac_r;
    flaps_nxt  = flaps_r;
    steps_nxt  = steps_r;
    seek_nxt   = seek_r;
    cool_nxt   = cool_r;
    pend_nxt   = pend_r;
    fail_nxt   = fail_r;
    pulse      = 1'b0;
    halt       = 1'b0;
    frac_sum   = '0;

    if (go) begin
      case (cmd)
        fdps_pkg::CMD_TARGET: begin
          wanted_nxt = (target < fdps_pkg::FLAP_W'(FLAP_COUNT)) ? target : '0;
        end
        fdps_pkg::CMD_HOME: begin
          pend_nxt = 1'b1;
        end
        fdps_pkg::CMD_TICK: begin
          if (cool_nxt != '0) begin
            cool_nxt = cool_nxt - 1'b1;
          end

          // Move start, only from idle. A pending homing ignores the cooldown.
          if (phase_nxt == PH_IDLE) begin
            if (pend_nxt) begin
              pend_nxt  = 1'b0;
              flaps_nxt = '0;
              steps_nxt = '0;
              phase_nxt = PH_HOME;
            end else if (shown_nxt != wanted_nxt && cool_nxt == '0) begin
              cool_nxt  = cooldown_ticks;
              steps_nxt = '0;
              if (wanted_nxt >= shown_nxt) begin
                flaps_nxt = wanted_nxt - shown_nxt;
                phase_nxt = PH_FWD;
              end else begin
                flaps_nxt = wanted_nxt;
                phase_nxt = PH_HOME;
              end
            end
          end

          // Phases only fall forward, so one ordered pass covers every chain.
          if (phase_nxt == PH_HOME) begin
            if (hall) begin
              seek_nxt  = SEEK_W'(ESCAPE_STEPS);
              steps_nxt = STEP_W'(ESCAPE_STEPS);
              phase_nxt = PH_ESCAPE;
            end else begin
              fail_nxt  = 1'b0;
              shown_nxt = '0;
              frac_nxt  = '0;
              steps_nxt = STEP_W'(home_offset);
              phase_nxt = PH_OFFSET;
            end
          end

          if (!halt && phase_nxt == PH_ESCAPE) begin
            if (steps_nxt != '0) begin
              steps_nxt = steps_nxt - 1'b1;
              pulse     = 1'b1;
              halt      = 1'b1;
            end
            if (steps_nxt == '0) begin
              if (seek_nxt > SEEK_W'(SEEK_LIMIT)) begin
                phase_nxt  = PH_IDLE;
                shown_nxt  = '0;
                wanted_nxt = '0;
                flaps_nxt  = '0;
                steps_nxt  = '0;
                fail_nxt   = 1'b1;
              end else begin
                seek_nxt  = seek_nxt + 1'b1;
                phase_nxt = PH_SEEK;
              end
            end
          end

          if (!halt && phase_nxt == PH_SEEK) begin
            if (!hall) begin
              fail_nxt  = 1'b0;
              shown_nxt = '0;
              frac_nxt  = '0;
              steps_nxt = STEP_W'(home_offset);
              phase_nxt = PH_OFFSET;
            end else begin
              if (seek_nxt > SEEK_W'(SEEK_LIMIT)) begin
                phase_nxt  = PH_IDLE;
                shown_nxt  = '0;
                wanted_nxt = '0;
                flaps_nxt  = '0;
                steps_nxt  = '0;
                fail_nxt   = 1'b1;
              end else begin
                seek_nxt = seek_nxt + 1'b1;
              end
              pulse = 1'b1;
              halt  = 1'b1;
            end
          end

          if (!halt && phase_nxt == PH_OFFSET) begin
            if (steps_nxt != '0) begin
              steps_nxt = steps_nxt - 1'b1;
              pulse     = 1'b1;
              halt      = 1'b1;
            end
            if (steps_nxt == '0) begin
              phase_nxt = (flaps_nxt != '0) ? PH_FWD : PH_IDLE;
            end
          end

          if (!halt && phase_nxt == PH_FWD) begin
            halt = 1'b1;
            if (steps_nxt == '0 && flaps_nxt == '0) begin
              phase_nxt = PH_IDLE;
            end else begin
              if (steps_nxt == '0) begin
                // Whole steps of one flap plus the carried fraction.
                frac_sum = {1'b0, frac_nxt} + (FRAC_W + 1)'(FLAP_REM);
                if (frac_sum > (FRAC_W + 1)'(FLAP_COUNT)) begin
                  steps_nxt = STEP_W'(FLAP_STEPS + 1);
                  frac_nxt  = FRAC_W'(frac_sum - (FRAC_W + 1)'(FLAP_COUNT));
                end else begin
                  steps_nxt = STEP_W'(FLAP_STEPS);
                  frac_nxt  = frac_sum[FRAC_W-1:0];
                end
                flaps_nxt = flaps_nxt - 1'b1;
              end
              steps_nxt = steps_nxt - 1'b1;
              pulse     = 1'b1;
              if (steps_nxt == '0) begin
                shown_nxt = shown_nxt + 1'b1;
                if (flaps_nxt == '0) begin
                  phase_nxt = PH_IDLE;
                end
              end
            end
          end

          if (!halt) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result.step_pulse    = pulse;
    result.motor_enabled = (phase_nxt != PH_IDLE) || pulse;
    result.busy_rotating = (phase_nxt != PH_IDLE) || pulse;
    result.shown_flap    = shown_nxt;
    result.home_failed   = fail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      shown_r  <= '0;
      wanted_r <= '0;
      frac_r   <= '0;
      flaps_r  <= '0;
      steps_r  <= '0;
      seek_r   <= '0;
      cool_r   <= '0;
      pend_r   <= 1'b0;
      fail_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      shown_r  <= shown_nxt;
      wanted_r <= wanted_nxt;
      frac_r   <= frac_nxt;
      flaps_r  <= flaps_nxt;
      steps_r  <= steps_nxt;
      seek_r   <= seek_nxt;
      cool_r   <= cool_nxt;
      pend_r   <= pend_nxt;
      fail_r   <= fail_nxt;
    end
  end

endmodule

// ----- rtl/flap_drum_position_sequencer.sv -----
// ----------------------------------------------------------------------------
// flap_drum_position_sequencer
// Step sequencer for a one-way drum of flaps with hall-marker homing.
// ----------------------------------------------------------------------------
// Each input word is a tick (carrying the hall level), a new target flap or a
// homing request, and each produces exactly one result word: whether a motor
// step was issued, whether the coils are driven and a move is in progress,
// the flap now shown, and whether the last homing failed. A word passes
// through an input register, the combinational update logic and a result
// register, and a new word can be accepted every cycle while out_ready
// keeps the result register moving; the result register lets the next word
// enter while the previous result still waits on out_ready. The single
// update stage in the core handles one word per cycle under that condition.
//
// Forward moves step whole flaps, each taking STEPS_PER_REV / FLAP_COUNT steps
// plus an extra step whenever the accumulated remainder numerator exceeds
// FLAP_COUNT. A target below the shown flap homes first: escape the marker
// (ESCAPE_STEPS), seek it one step per tick, then step home_offset_steps past
// it. A seek beyond three revolutions stops the motor, shows flap zero, drops
// the move and raises home_failed. A move starts only once cooldown_ticks
// ticks have passed since the previous start; a homing request ignores that.
// Target values at or above FLAP_COUNT select flap zero. Configuration
// (index 0: home_offset_steps, index 1: cooldown_ticks) must be written only
// while the block is idle.
// ----------------------------------------------------------------------------
module flap_drum_position_sequencer #(
  parameter int STEPS_PER_REV = fdps_pkg::STEPS_PER_REV_DEF,
  parameter int FLAP_COUNT    = fdps_pkg::FLAP_COUNT_DEF,
  parameter int ESCAPE_STEPS  = fdps_pkg::ESCAPE_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fdps_pkg::CMD_W-1:0]       in_command,
  input  logic [fdps_pkg::FLAP_W-1:0]      in_flap_target,
  input  logic                             in_hall_level,

  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_step_pulse,
  output logic                             out_motor_enabled,
  output logic                             out_busy_rotating,
  output logic [fdps_pkg::FLAP_W-1:0]      out_shown_flap,
  output logic                             out_home_failed,

  input  logic                             cfg_we,
  input  logic [fdps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fdps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // Configuration registers.
  logic [fdps_pkg::OFFSET_W-1:0]   home_offset_r;
  logic [fdps_pkg::COOLDOWN_W-1:0] cooldown_r;

  // Input register.
  logic                        in_full_r;
  logic [fdps_pkg::CMD_W-1:0]  cmd_r;
  logic [fdps_pkg::FLAP_W-1:0] target_r;
  logic                        hall_r;

  // Result register.
  logic                        out_valid_r;
  fdps_pkg::result_t           result_r;
  fdps_pkg::result_t           result;

  logic                        fire;

  // The held word is processed when the result register is free or is
  // being emptied in this same cycle.
  assign fire     = in_full_r && (!out_valid_r || out_ready);
  assign in_ready = !in_full_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_offset_r <= fdps_pkg::HOME_OFFSET_RST;
      cooldown_r    <= fdps_pkg::COOLDOWN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fdps_pkg::CFG_HOME_OFFSET: home_offset_r <= cfg_wdata[fdps_pkg::OFFSET_W-1:0];
        fdps_pkg::CFG_COOLDOWN:    cooldown_r    <= cfg_wdata[fdps_pkg::COOLDOWN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full_r <= 1'b1;
    end else if (fire) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r    <= in_command;
      target_r <= in_flap_target;
      hall_r   <= in_hall_level;
    end
  end

  fdps_core #(
    .STEPS_PER_REV (STEPS_PER_REV),
    .FLAP_COUNT    (FLAP_COUNT),
    .ESCAPE_STEPS  (ESCAPE_STEPS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .go             (fire),
    .cmd            (cmd_r),
    .target         (target_r),
    .hall           (hall_r),
    .home_offset    (home_offset_r),
    .cooldown_ticks (cooldown_r),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_step_pulse    = result_r.step_pulse;
  assign out_motor_enabled = result_r.motor_enabled;
  assign out_busy_rotating = result_r.busy_rotating;
  assign out_shown_flap    = result_r.shown_flap;
  assign out_home_failed   = result_r.home_failed;

endmodule

// ----- tb/flap_drum_checker.sv -----
// ----------------------------------------------------------------------------
// flap_drum_checker
// Watches the word channels and the register port of the flap drum position
// sequencer. It keeps its own copy of the drum state, predicts the result of
// every accepted input word, and compares each result word field by field.
// ----------------------------------------------------------------------------
module flap_drum_checker
  import fdps_pkg::*;
#(
  parameter int STEPS_PER_REV = STEPS_PER_REV_DEF,
  parameter int FLAP_COUNT    = FLAP_COUNT_DEF,
  parameter int ESCAPE_STEPS  = ESCAPE_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [CMD_W-1:0]       in_command,
  input  logic [FLAP_W-1:0]      in_flap_target,
  input  logic                   in_hall_level,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   out_step_pulse,
  input  logic                   out_motor_enabled,
  input  logic                   out_busy_rotating,
  input  logic [FLAP_W-1:0]      out_shown_flap,
  input  logic                   out_home_failed,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int unsigned            mismatch_total,
  output int unsigned            reports_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BASE_STEPS  = STEPS_PER_REV / FLAP_COUNT;
  localparam int REMAINDER   = STEPS_PER_REV % FLAP_COUNT;
  localparam int SEEK_LIMIT  = 3 * STEPS_PER_REV;
  localparam int SHOW_FAULTS = 10;

  typedef enum logic [2:0] {
    DRUM_IDLE,
    DRUM_HOME,
    DRUM_ESCAPE,
    DRUM_SEEK,
    DRUM_OFFSET,
    DRUM_FORWARD
  } drum_phase_t;

  drum_phase_t           phase;
  logic [FLAP_W-1:0]     shown;
  logic [FLAP_W-1:0]     wanted;
  int unsigned           frac;
  logic [FLAP_W-1:0]     flaps_left;
  int unsigned           steps_left;
  int unsigned           seek_count;
  logic [COOLDOWN_W-1:0] cooldown_count;
  logic                  home_pending;
  logic                  fail_flag;
  logic [OFFSET_W-1:0]   offset_cfg;
  logic [COOLDOWN_W-1:0] cooldown_cfg;

  result_t due_reports[$];

  initial begin
    mismatch_total = 0;
    reports_due    = 0;
  end

  // Marker found: flap zero is reached after the configured offset.
  function automatic void enter_offset();
    fail_flag  = 1'b0;
    shown      = '0;
    frac       = '0;
    steps_left = offset_cfg;
    phase      = DRUM_OFFSET;
  endfunction

  function automatic void abort_homing();
    phase      = DRUM_IDLE;
    shown      = '0;
    wanted     = '0;
    flaps_left = '0;
    steps_left = '0;
    fail_flag  = 1'b1;
  endfunction

  function automatic void escape_done();
    if (seek_count > SEEK_LIMIT) begin
      abort_homing();
    end else begin
      seek_count++;
      phase = DRUM_SEEK;
    end
  endfunction

  function automatic void offset_done();
    steps_left = '0;
    phase      = (flaps_left != 0) ? DRUM_FORWARD : DRUM_IDLE;
  endfunction

  // One tick of motion; returns whether a step is issued. Phases that only
  // decide fall through to the next phase within the same tick.
  function automatic logic drum_tick(logic hall);
    for (int pass = 0; pass < 8; pass++) begin
      case (phase)
        DRUM_HOME: begin
          if (hall) begin
            seek_count = ESCAPE_STEPS;
            steps_left = ESCAPE_STEPS;
            phase      = DRUM_ESCAPE;
          end else begin
            enter_offset();
          end
        end
        DRUM_ESCAPE: begin
          if (steps_left == 0) begin
            escape_done();
          end else begin
            steps_left--;
            if (steps_left == 0) escape_done();
            return 1'b1;
          end
        end
        DRUM_SEEK: begin
          if (!hall) begin
            enter_offset();
          end else begin
            if (seek_count > SEEK_LIMIT) abort_homing();
            else seek_count++;
            return 1'b1;
          end
        end
        DRUM_OFFSET: begin
          if (steps_left == 0) begin
            offset_done();
          end else begin
            steps_left--;
            if (steps_left == 0) offset_done();
            return 1'b1;
          end
        end
        DRUM_FORWARD: begin
          if (steps_left == 0) begin
            if (flaps_left == 0) begin
              phase = DRUM_IDLE;
              return 1'b0;
            end
            // Whole steps per flap, plus one whenever the remainder
            // numerator runs past the flap count.
            steps_left = BASE_STEPS;
            frac       = frac + REMAINDER;
            if (frac > FLAP_COUNT) begin
              steps_left++;
              frac = frac - FLAP_COUNT;
            end
            flaps_left--;
          end
          steps_left--;
          if (steps_left == 0) begin
            shown = shown + 1'b1;
            if (flaps_left == 0) phase = DRUM_IDLE;
          end
          return 1'b1;
        end
        default: begin
          phase = DRUM_IDLE;
          return 1'b0;
        end
      endcase
    end
    return 1'b0;
  endfunction

  function automatic result_t advance_drum(logic [CMD_W-1:0] cmd,
                                           logic [FLAP_W-1:0] target,
                                           logic hall);
    result_t r;
    logic    pulse;
    logic    busy;
    pulse = 1'b0;
    case (cmd)
      CMD_TARGET: wanted = (target < FLAP_COUNT) ? target : '0;
      CMD_HOME:   home_pending = 1'b1;
      CMD_TICK: begin
        if (cooldown_count != 0) cooldown_count--;
        if (phase == DRUM_IDLE) begin
          if (home_pending) begin
            home_pending = 1'b0;
            flaps_left   = '0;
            steps_left   = '0;
            phase        = DRUM_HOME;
          end else if (shown != wanted && cooldown_count == 0) begin
            cooldown_count = cooldown_cfg;
            steps_left     = '0;
            if (wanted >= shown) begin
              flaps_left = wanted - shown;
              phase      = DRUM_FORWARD;
            end else begin
              flaps_left = wanted;
              phase      = DRUM_HOME;
            end
          end
        end
        pulse = drum_tick(hall);
      end
      default: ;
    endcase
    busy            = (phase != DRUM_IDLE) || pulse;
    r.step_pulse    = pulse;
    r.motor_enabled = busy;
    r.busy_rotating = busy;
    r.shown_flap    = shown;
    r.home_failed   = fail_flag;
    return r;
  endfunction

  function automatic void log_fault(string what, result_t want, result_t seen);
    if (mismatch_total < SHOW_FAULTS) begin
      $display("%0t %s: expected pulse=%0b motor=%0b busy=%0b flap=%0d failed=%0b",
               $time, what, want.step_pulse, want.motor_enabled, want.busy_rotating,
               want.shown_flap, want.home_failed);
      $display("%0t %s: actual   pulse=%0b motor=%0b busy=%0b flap=%0d failed=%0b",
               $time, what, seen.step_pulse, seen.motor_enabled, seen.busy_rotating,
               seen.shown_flap, seen.home_failed);
    end
    mismatch_total++;
  endfunction

  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    if (!rst_n) begin
      phase          = DRUM_IDLE;
      shown          = '0;
      wanted         = '0;
      frac           = '0;
      flaps_left     = '0;
      steps_left     = '0;
      seek_count     = '0;
      cooldown_count = '0;
      home_pending   = 1'b0;
      fail_flag      = 1'b0;
      offset_cfg     = HOME_OFFSET_RST;
      cooldown_cfg   = COOLDOWN_RST;
      due_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HOME_OFFSET: offset_cfg   = cfg_wdata[OFFSET_W-1:0];
          CFG_COOLDOWN:    cooldown_cfg = cfg_wdata[COOLDOWN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen.step_pulse    = out_step_pulse;
        seen.motor_enabled = out_motor_enabled;
        seen.busy_rotating = out_busy_rotating;
        seen.shown_flap    = out_shown_flap;
        seen.home_failed   = out_home_failed;
        if (due_reports.size() == 0) begin
          log_fault("unexpected word", '0, seen);
        end else begin
          want = due_reports.pop_front();
          if (seen.step_pulse    !== want.step_pulse    ||
              seen.motor_enabled !== want.motor_enabled ||
              seen.busy_rotating !== want.busy_rotating ||
              seen.shown_flap    !== want.shown_flap    ||
              seen.home_failed   !== want.home_failed) begin
            log_fault("mismatch", want, seen);
          end
        end
      end
      if (in_valid && in_ready) begin
        due_reports.push_back(advance_drum(in_command, in_flap_target, in_hall_level));
      end
    end
    reports_due = due_reports.size();
  end

endmodule

// ----- tb/flap_drum_position_sequencer_tb.sv -----
// ----------------------------------------------------------------------------
// flap_drum_position_sequencer_tb
// Drives target, homing and tick words into the flap drum sequencer under
// random idle gaps and back-pressure, steps through several register
// settings, and reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module flap_drum_position_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fdps_pkg::*;

  // The command code with no function; the block must ignore it.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  // Cycles allowed after the last result before registers are touched or the
  // verdict is given.
  localparam int TAIL = 8;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [CMD_W-1:0]       in_command;
  logic [FLAP_W-1:0]      in_flap_target;
  logic                   in_hall_level;
  logic                   out_valid;
  logic                   out_ready;
  logic                   out_step_pulse;
  logic                   out_motor_enabled;
  logic                   out_busy_rotating;
  logic [FLAP_W-1:0]      out_shown_flap;
  logic                   out_home_failed;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  int unsigned            mismatch_total;
  int unsigned            reports_due;

  // While steady is set, neither side inserts gaps, so the block also sees
  // runs of back-to-back words.
  logic                   steady = 1'b0;
  // Busy flag of the most recent result word; used to let a move finish
  // before the registers change.
  logic                   last_busy = 1'b0;
  int unsigned            cycle_count = 0;

  always #2 clk = ~clk;

  flap_drum_position_sequencer DUT (.*);

  flap_drum_checker CHECK (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && out_ready) last_busy <= out_busy_rotating;
  end

  // The hall sensor mostly reads high; now and then the marker passes.
  function automatic logic marker_level();
    return ($urandom_range(0, 19) != 0);
  endfunction

  // Presents one word after a random gap and returns at the falling edge
  // after it was accepted. Valid stays high on return, so a following word
  // without a gap goes out back to back.
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [FLAP_W-1:0] target,
                           logic hall);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_flap_target <= target;
    in_hall_level  <= hall;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  // Drops valid and waits until every word sent so far has its result.
  task automatic drain();
    in_valid <= 1'b0;
    while (reports_due != 0) @(negedge clk);
    repeat (TAIL) @(negedge clk);
  endtask

  // Ticks the drum until a move or homing in progress has ended. The marker
  // shows often here so that seeks end quickly.
  task automatic settle();
    drain();
    while (last_busy) begin
      send_word(CMD_TICK, FLAP_W'($urandom), 1'($urandom_range(0, 1)));
      drain();
    end
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Random traffic: a command, mostly a new target and mostly close to the
  // low flaps so that moves finish, followed by a run of ticks. Commands
  // often land while the drum is still moving.
  task automatic run_traffic(int words);
    int                sent;
    int                pick;
    int                burst;
    int                spread;
    logic [FLAP_W-1:0] target;
    sent = 0;
    while (sent < words) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        spread = $urandom_range(0, 9);
        if (spread < 7) target = FLAP_W'($urandom_range(0, 4));
        else if (spread < 9) target = FLAP_W'($urandom_range(0, FLAP_COUNT_DEF - 1));
        else target = FLAP_W'($urandom_range(0, 63));
        send_word(CMD_TARGET, target, 1'($urandom_range(0, 1)));
        sent++;
      end else if (pick < 7) begin
        send_word(CMD_HOME, FLAP_W'($urandom), 1'($urandom_range(0, 1)));
        sent++;
      end else if (pick == 7) begin
        send_word(CMD_SPARE, FLAP_W'($urandom), 1'($urandom_range(0, 1)));
      end
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 40);
      repeat (burst) send_word(CMD_TICK, FLAP_W'($urandom), marker_level());
      sent += burst;
    end
  endtask

  // Registers change only with no word in flight and the drum at rest.
  task automatic run_phase(logic [OFFSET_W-1:0] offset, logic [COOLDOWN_W-1:0] cooldown,
                           int words);
    settle();
    write_reg(CFG_HOME_OFFSET, CFG_DATA_W'(offset));
    write_reg(CFG_COOLDOWN, cooldown);
    run_traffic(words);
  endtask

  // Result side: before each result it may hold ready low, except while steady is set.
  initial begin : sink
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // Switches between stretches with random gaps and stretches without.
  initial begin : pacing
    forever begin
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(20, 200)) @(posedge clk);
    end
  end

  initial begin : watchdog
    wait (cycle_count == CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = CMD_TICK;
    in_flap_target = '0;
    in_hall_level  = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = CFG_HOME_OFFSET;
    cfg_wdata      = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words with the reset settings. Targets at and above the flap
    // count fall back to flap zero, the unused command changes nothing, and
    // the first move may start at once since no cooldown runs after reset.
    send_word(CMD_TICK, 6'd63, 1'b1);
    send_word(CMD_TARGET, 6'd63, 1'b0);
    send_word(CMD_TARGET, FLAP_W'(FLAP_COUNT_DEF), 1'b1);
    send_word(CMD_SPARE, 6'd44, 1'b0);
    send_word(CMD_TICK, 6'd0, 1'b0);
    send_word(CMD_TARGET, 6'd3, 1'b0);
    repeat (4) send_word(CMD_TICK, FLAP_W'($urandom), marker_level());
    // A lower target and a homing request while moving are only recorded.
    send_word(CMD_TARGET, 6'd0, 1'b1);
    send_word(CMD_HOME, 6'd21, 1'b0);
    repeat (4) send_word(CMD_TICK, FLAP_W'($urandom), 1'b0);

    // The move finishes with the marker in view, so the pending homing goes
    // straight to the offset and clears the failure flag.
    drain();
    while (last_busy) begin
      send_word(CMD_TICK, FLAP_W'($urandom), 1'b0);
      drain();
    end

    // Register extremes and random settings. The longest cooldown comes
    // last, since it blocks further moves for the rest of the run.
    run_phase('0, '0, 300);
    run_phase(8'hFF, 16'd1, 300);
    run_phase(OFFSET_W'($urandom_range(1, 254)), COOLDOWN_W'($urandom_range(0, 300)), 300);
    run_phase(OFFSET_W'($urandom_range(0, 255)), COOLDOWN_W'($urandom_range(2, 60)), 250);
    run_phase(HOME_OFFSET_RST, 16'hFFFF, 120);

    drain();
    if (mismatch_total == 0 && reports_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
